FILE: rtl/core/esfc_pkg.sv
// Shared types, constants and helpers for the elevator stepper floor controller.
`default_nettype none

package esfc_pkg;

  localparam int unsigned TOP_FLOOR = 5;

  localparam int unsigned BUTTON_W = 8;
  localparam int unsigned FLOOR_W  = 3;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned TURNS_W  = 8;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TURNS_W-1:0] TURNS_RESET = 8'd10;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5000;

  localparam logic [PHASE_W-1:0] LAST_PHASE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TURNS_PER_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY      = 2'd1;

  typedef struct packed {
    logic               valid;
    logic [FLOOR_W-1:0] floor;
  } esfc_req_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coil;
    logic [FLOOR_W-1:0] floor;
    logic               busy;
  } esfc_status_t;

  // Wave drive: one coil at a time, 1,2,4,8 going up and 8,4,2,1 going down.
  function automatic logic [COIL_W-1:0] coil_for(input logic [PHASE_W-1:0] phase,
                                                 input logic up);
    logic [COIL_W-1:0] pattern;
    if (up) begin
      pattern = 4'b0001 << phase;
    end else begin
      pattern = 4'b1000 >> phase;
    end
    return pattern;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/esfc_req_decode.sv
// Button port decoder: turns a single-bit button value into a floor request.
`default_nettype none

module esfc_req_decode (
  input  wire logic [esfc_pkg::BUTTON_W-1:0] button_port,
  input  wire logic [esfc_pkg::FLOOR_W-1:0]  current_floor,
  output esfc_pkg::esfc_req_t                req
);

  logic [esfc_pkg::FLOOR_W-1:0] floor_sel;

  // Only an exact single-bit value counts; all compares are independent.
  always_comb begin
    floor_sel = '0;
    for (int k = 0; k < esfc_pkg::TOP_FLOOR; k++) begin
      if (button_port == (esfc_pkg::BUTTON_W'(1) << k)) begin
        floor_sel = esfc_pkg::FLOOR_W'(k + 1);
      end
    end
  end

  assign req.floor = floor_sel;
  assign req.valid = (floor_sel != '0) && (floor_sel != current_floor);

endmodule

`default_nettype wire

FILE: rtl/core/esfc_motion.sv
// Motion state: floor tracking, phase sequencing and coil drive.
`default_nettype none

module esfc_motion (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire esfc_pkg::esfc_req_t           req,
  input  wire logic [esfc_pkg::TURNS_W-1:0]  turns_per_floor,
  input  wire logic [esfc_pkg::DELAY_W-1:0]  step_delay,
  output logic [esfc_pkg::FLOOR_W-1:0]       current_floor,
  output esfc_pkg::esfc_status_t             status_nxt
);

  logic [esfc_pkg::FLOOR_W-1:0] current_floor_r, current_floor_nxt;
  logic [esfc_pkg::FLOOR_W-1:0] target_floor_r,  target_floor_nxt;
  logic                         moving_up_r,     moving_up_nxt;
  logic                         moving_r,        moving_nxt;
  logic [esfc_pkg::PHASE_W-1:0] phase_index_r,   phase_index_nxt;
  logic [esfc_pkg::TURNS_W-1:0] cycle_count_r,   cycle_count_nxt;
  logic [esfc_pkg::DELAY_W-1:0] delay_count_r,   delay_count_nxt;
  logic [esfc_pkg::COIL_W-1:0]  coil_register_r, coil_register_nxt;

  logic [esfc_pkg::DELAY_W-1:0] hold;
  logic                         delay_done;
  logic [esfc_pkg::FLOOR_W-1:0] floor_step;

  assign hold       = (step_delay == '0) ? esfc_pkg::DELAY_W'(1) : step_delay;
  assign delay_done = ({1'b0, delay_count_r} + (esfc_pkg::DELAY_W+1)'(1)) >= {1'b0, hold};
  assign floor_step = moving_up_r ? (current_floor_r + esfc_pkg::FLOOR_W'(1))
                                  : (current_floor_r - esfc_pkg::FLOOR_W'(1));

  always_comb begin
    current_floor_nxt = current_floor_r;
    target_floor_nxt  = target_floor_r;
    moving_up_nxt     = moving_up_r;
    moving_nxt        = moving_r;
    phase_index_nxt   = phase_index_r;
    cycle_count_nxt   = cycle_count_r;
    delay_count_nxt   = delay_count_r;
    coil_register_nxt = coil_register_r;
    if (step_en) begin
      if (moving_r) begin
        if (delay_done) begin
          delay_count_nxt = '0;
          if (phase_index_r == esfc_pkg::LAST_PHASE) begin
            phase_index_nxt = '0;
            if (cycle_count_r >= turns_per_floor) begin
              cycle_count_nxt   = '0;
              current_floor_nxt = floor_step;
              if (floor_step == target_floor_r) begin
                moving_nxt = 1'b0;
              end
            end else begin
              cycle_count_nxt = cycle_count_r + esfc_pkg::TURNS_W'(1);
            end
          end else begin
            phase_index_nxt = phase_index_r + esfc_pkg::PHASE_W'(1);
          end
          // On arrival the coil keeps the last pattern it was driving.
          if (moving_nxt) begin
            coil_register_nxt = esfc_pkg::coil_for(phase_index_nxt, moving_up_r);
          end
        end else begin
          delay_count_nxt = delay_count_r + esfc_pkg::DELAY_W'(1);
        end
      end else if (req.valid) begin
        target_floor_nxt  = req.floor;
        moving_up_nxt     = req.floor > current_floor_r;
        moving_nxt        = 1'b1;
        phase_index_nxt   = '0;
        cycle_count_nxt   = '0;
        delay_count_nxt   = '0;
        coil_register_nxt = esfc_pkg::coil_for('0, req.floor > current_floor_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_floor_r <= '0;
      target_floor_r  <= '0;
      moving_up_r     <= 1'b0;
      moving_r        <= 1'b0;
      phase_index_r   <= '0;
      cycle_count_r   <= '0;
      delay_count_r   <= '0;
      coil_register_r <= '0;
    end else begin
      current_floor_r <= current_floor_nxt;
      target_floor_r  <= target_floor_nxt;
      moving_up_r     <= moving_up_nxt;
      moving_r        <= moving_nxt;
      phase_index_r   <= phase_index_nxt;
      cycle_count_r   <= cycle_count_nxt;
      delay_count_r   <= delay_count_nxt;
      coil_register_r <= coil_register_nxt;
    end
  end

  assign current_floor    = current_floor_r;
  assign status_nxt.coil  = coil_register_nxt;
  assign status_nxt.floor = current_floor_nxt;
  assign status_nxt.busy  = moving_nxt;

`ifndef SYNTHESIS
  a_busy_coil_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> $onehot(coil_register_r))
    else $error("coil drive is not one-hot during a move");

  a_busy_not_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (current_floor_r != target_floor_r))
    else $error("move in progress while already at the target floor");

  a_idle_no_request_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && step_en && !moving_r && !req.valid) |=>
      (!moving_r && $stable(current_floor_r) && $stable(coil_register_r)))
    else $error("idle beat without a request changed the motion state");

  a_phase_holds_in_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && step_en && moving_r && !delay_done) |=>
      ($stable(phase_index_r) && $stable(coil_register_r) && moving_r))
    else $error("coil phase advanced before its hold time ran out");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/elevator_stepper_floor_controller.sv
// Top level of the elevator stepper floor controller.
`default_nettype none

// Each input beat is one timing tick of the controller and yields exactly one
// result beat carrying the coil drive, the floor shown on the display and the
// busy flag as they stand after that tick. While idle, a button value equal to
// exactly 1, 2, 4, 8 or 16 requests floors 1 to 5; any other value, a request
// for the current floor and any input during a move are ignored. A move drives
// one coil at a time (1,2,4,8 up, 8,4,2,1 down), holds each phase for
// step_delay ticks (zero acts as one) and spends turns_per_floor+1 four-phase
// cycles per floor. The block takes one beat every clock and produces one
// result beat every clock while the output is not stalled; each beat passes
// through the input register and then the result register, with the whole
// state update done in the single combinational pass between them. A stalled
// output holds both stages in place. Configuration writes are always ready;
// register index 0 is turns_per_floor (low 8 data bits), index 1 is
// step_delay, and other indexes are dropped.
module elevator_stepper_floor_controller (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [esfc_pkg::BUTTON_W-1:0]    in_button_port,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [esfc_pkg::COIL_W-1:0]           out_coil_pattern,
  output logic [esfc_pkg::FLOOR_W-1:0]          out_floor_display,
  output logic                                  out_busy_res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [esfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [esfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [esfc_pkg::TURNS_W-1:0] turns_per_floor_r;
  logic [esfc_pkg::DELAY_W-1:0] step_delay_r;

  // Input register.
  logic                          s1_valid_r;
  logic [esfc_pkg::BUTTON_W-1:0] s1_button_r;

  // Result register.
  logic                   out_valid_r;
  esfc_pkg::esfc_status_t out_status_r;

  logic                         advance;
  esfc_pkg::esfc_req_t          req;
  esfc_pkg::esfc_status_t       status_nxt;
  logic [esfc_pkg::FLOOR_W-1:0] current_floor;

  // The buffered beat moves forward whenever the result slot is free or is
  // being emptied this cycle; the input register refills in the same cycle.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turns_per_floor_r <= esfc_pkg::TURNS_RESET;
      step_delay_r      <= esfc_pkg::DELAY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        esfc_pkg::REG_TURNS_PER_FLOOR: begin
          turns_per_floor_r <= cfg_data[esfc_pkg::TURNS_W-1:0];
        end
        esfc_pkg::REG_STEP_DELAY: begin
          step_delay_r <= cfg_data[esfc_pkg::DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_button_r <= in_button_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
    end
  end

  esfc_req_decode u_req_decode (
    .button_port   (s1_button_r),
    .current_floor (current_floor),
    .req           (req)
  );

  esfc_motion u_motion (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (advance),
    .req             (req),
    .turns_per_floor (turns_per_floor_r),
    .step_delay      (step_delay_r),
    .current_floor   (current_floor),
    .status_nxt      (status_nxt)
  );

  assign out_valid         = out_valid_r;
  assign out_coil_pattern  = out_status_r.coil;
  assign out_floor_display = out_status_r.floor;
  assign out_busy_res      = out_status_r.busy;

`ifndef SYNTHESIS
  a_out_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_coil_pattern)
      && $stable(out_floor_display) && $stable(out_busy_res)))
    else $error("result beat changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  a_floor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_floor_display <= esfc_pkg::FLOOR_W'(esfc_pkg::TOP_FLOOR)))
    else $error("displayed floor out of range");
`endif

endmodule

`default_nettype wire
